// ----- hdl/pcowt_pkg.sv -----
// Package: window types, fixed window constants and decode helpers for the outbound translator.
package pcowt_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned SIZE_W   = 33;
    localparam int unsigned WREG_W   = 24;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [1:0] REG_MEM_A = 2'd0;
    localparam logic [1:0] REG_MEM_B = 2'd1;
    localparam logic [1:0] REG_IO    = 2'd2;

    localparam logic OP_MEM = 1'b0;
    localparam logic OP_IO  = 1'b1;

    localparam logic [IDX_W-1:0] IDX_FIXED = 2'd0;
    localparam logic [IDX_W-1:0] IDX_PROG1 = 2'd1;
    localparam logic [IDX_W-1:0] IDX_PROG2 = 2'd2;

    localparam logic [ADDR_W-1:0] FIXED_LO = 32'h3000_0000;

    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] sys;
        logic [ADDR_W-1:0] pci;
        logic [SIZE_W-1:0] size;
    } win_t;

    localparam win_t FIXED_MEM_WIN = '{
        vld:  1'b1,
        sys:  32'h3010_0000,
        pci:  32'h0010_0000,
        size: 33'h0_00f0_0000
    };

    localparam win_t FIXED_IO_WIN = '{
        vld:  1'b1,
        sys:  32'h3000_0000,
        pci:  32'h0000_0000,
        size: 33'h0_0001_0000
    };

    // size in 16 MiB units: 16 - low nibble of mask byte (1..16)
    function automatic logic [4:0] win_units(input logic [WREG_W-1:0] r);
        win_units = 5'd16 - {1'b0, r[3:0]};
    endfunction

    function automatic win_t win_decode(input logic [WREG_W-1:0] r, input logic en);
        win_t w;
        w.vld  = en;
        w.sys  = FIXED_LO | {4'b0000, r[19:16], 24'h00_0000};
        w.pci  = {r[15:8], 24'h00_0000};
        w.size = {4'b0000, win_units(r), 24'h00_0000};
        return w;
    endfunction

    // fixed region is one 16 MiB unit at the bottom of the system range
    function automatic logic over_fixed(input logic [WREG_W-1:0] r);
        over_fixed = (r[19:16] == 4'h0);
    endfunction

    function automatic logic over_win(input logic [WREG_W-1:0] a, input logic [WREG_W-1:0] b);
        logic [5:0] a_lo;
        logic [5:0] a_hi;
        logic [5:0] b_lo;
        logic [5:0] b_hi;
        a_lo = {2'b00, a[19:16]};
        b_lo = {2'b00, b[19:16]};
        a_hi = a_lo + {1'b0, win_units(a)};
        b_hi = b_lo + {1'b0, win_units(b)};
        over_win = (a_lo < b_hi) && (b_lo < a_hi);
    endfunction

endpackage

// ----- hdl/pci_outbound_window_translate.sv -----
// Top level: PCI outbound address window translator with APB window registers.
//
//  channel   dir  handshake                    payload
//  s_        in   s_tvalid / s_tready          tdata: pci_addr, access_length; tuser: op
//  m_        out  m_tvalid / m_tready          tdata: sys_addr, window_index; tuser: hit
//  apb       in   psel & penable & pwrite      mem_window_a @0, mem_window_b @4, io_window @8
//
// One item per cycle is sustained while m_tready is high.
// Stage 1 subtracts the window PCI base, stage 2 does the bound add/compare and the
// system address add, stage 3 picks the first hitting window into the output register.
// A stall on m_ holds all three stages; bubbles close up. Reset clears valid bits and
// the window registers.
module pci_outbound_window_translate (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // [31:0] pci_addr, [63:32] access_length
    input  logic [0:0]                    s_tuser,   // [0] op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [31:0] sys_addr, [33:32] window_index
    output logic [0:0]                    m_tuser,   // [0] hit
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcowt_pkg::PADDR_W-1:0] paddr,
    input  logic [pcowt_pkg::PDATA_W-1:0] pwdata,
    output logic [pcowt_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import pcowt_pkg::*;

    logic [WREG_W-1:0] mem_a_reg;
    logic [WREG_W-1:0] mem_b_reg;
    logic [WREG_W-1:0] io_reg;
    logic              cfg_wr;

    logic              en_a;
    logic              en_b;
    logic              en_i;
    win_t              cand [3];
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] in_len;

    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              adv1;
    logic              adv2;
    logic              adv3;

    logic [2:0]        hit_w;
    logic [ADDR_W-1:0] sys_w [3];

    logic              hit_next;
    logic [ADDR_W-1:0] sys_next;
    logic [IDX_W-1:0]  idx_next;
    logic              hit_reg;
    logic [ADDR_W-1:0] sys_reg;
    logic [IDX_W-1:0]  idx_reg;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_a_reg <= '0;
            mem_b_reg <= '0;
            io_reg    <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MEM_A: mem_a_reg <= pwdata[WREG_W-1:0];
                REG_MEM_B: mem_b_reg <= pwdata[WREG_W-1:0];
                REG_IO:    io_reg    <= pwdata[WREG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MEM_A: prdata = {{(PDATA_W-WREG_W){1'b0}}, mem_a_reg};
            REG_MEM_B: prdata = {{(PDATA_W-WREG_W){1'b0}}, mem_b_reg};
            REG_IO:    prdata = {{(PDATA_W-WREG_W){1'b0}}, io_reg};
            default:   prdata = '0;
        endcase
    end

    // window enables and candidate list, in search order
    assign en_a = !over_fixed(mem_a_reg);
    assign en_b = !over_fixed(mem_b_reg) && !(en_a && over_win(mem_b_reg, mem_a_reg));
    assign en_i = !over_fixed(io_reg) && !(en_a && over_win(io_reg, mem_a_reg))
                  && !(en_b && over_win(io_reg, mem_b_reg));

    assign in_addr = s_tdata[31:0];
    assign in_len  = s_tdata[63:32];

    always_comb begin
        case (s_tuser[0])
            OP_IO: begin
                cand[0] = FIXED_IO_WIN;
                cand[1] = win_decode(io_reg, en_i);
                cand[2] = win_decode(io_reg, 1'b0);
            end
            default: begin
                cand[0] = FIXED_MEM_WIN;
                cand[1] = en_a ? win_decode(mem_a_reg, 1'b1) : win_decode(mem_b_reg, en_b);
                cand[2] = win_decode(mem_b_reg, en_a && en_b);
            end
        endcase
    end

    // pipeline flow control
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_chk
        pcowt_win_chk u_chk (
            .aclk      (aclk),
            .stage1_en (adv1),
            .stage2_en (adv2),
            .win       (cand[g]),
            .addr      (in_addr),
            .len       (in_len),
            .hit       (hit_w[g]),
            .sys_addr  (sys_w[g])
        );
    end

    // first hit wins
    always_comb begin
        hit_next = 1'b1;
        sys_next = '0;
        idx_next = IDX_FIXED;
        if (hit_w[0]) begin
            sys_next = sys_w[0];
        end else if (hit_w[1]) begin
            sys_next = sys_w[1];
            idx_next = IDX_PROG1;
        end else if (hit_w[2]) begin
            sys_next = sys_w[2];
            idx_next = IDX_PROG2;
        end else begin
            hit_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            hit_reg <= hit_next;
            sys_reg <= sys_next;
            idx_reg <= idx_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {6'b000000, idx_reg, sys_reg};
    assign m_tuser  = hit_reg;

endmodule

// ----- hdl/pcowt_win_chk.sv -----
// Two-stage containment check of an access against one window, with translated address.
module pcowt_win_chk (
    input  logic                         aclk,
    input  logic                         stage1_en,
    input  logic                         stage2_en,
    input  pcowt_pkg::win_t              win,
    input  logic [pcowt_pkg::ADDR_W-1:0] addr,
    input  logic [pcowt_pkg::ADDR_W-1:0] len,
    output logic                         hit,
    output logic [pcowt_pkg::ADDR_W-1:0] sys_addr
);
    import pcowt_pkg::*;

    logic [ADDR_W:0]   diff_next;
    logic              vld_reg;
    logic              below_reg;
    logic [ADDR_W-1:0] off_reg;
    logic [ADDR_W-1:0] len_reg;
    logic [ADDR_W-1:0] sys_reg;
    logic [SIZE_W-1:0] size_reg;

    logic [SIZE_W-1:0] end_next;
    logic              hit_next;
    logic              hit_reg;
    logic [ADDR_W-1:0] sys_addr_reg;

    assign diff_next = {1'b0, addr} - {1'b0, win.pci};

    always_ff @(posedge aclk) begin
        if (stage1_en) begin
            vld_reg   <= win.vld;
            below_reg <= diff_next[ADDR_W];
            off_reg   <= diff_next[ADDR_W-1:0];
            len_reg   <= len;
            sys_reg   <= win.sys;
            size_reg  <= win.size;
        end
    end

    assign end_next = {1'b0, off_reg} + {1'b0, len_reg};
    assign hit_next = vld_reg && !below_reg && (end_next <= size_reg);

    always_ff @(posedge aclk) begin
        if (stage2_en) begin
            hit_reg      <= hit_next;
            sys_addr_reg <= sys_reg + off_reg;
        end
    end

    assign hit      = hit_reg;
    assign sys_addr = sys_addr_reg;

endmodule

// ----- tb/sv/pci_outbound_window_translate_tb.sv -----
// Testbench: random and directed address translations checked against a window predictor.
`timescale 1ns / 100ps

module pci_outbound_window_translate_tb;

    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned RAND_PHASES  = 12;
    localparam int unsigned PHASE_ITEMS  = 96;
    localparam int unsigned PIPE_SETTLE  = 6;

    typedef struct {
        logic [63:0] sys;
        logic [63:0] pci;
        logic [63:0] size;
    } aperture_t;

    typedef struct {
        logic        hit;
        logic [31:0] sys_addr;
        logic [1:0]  window_index;
    } xlat_t;

    class window_scoreboard;
        logic [23:0] win_reg[3];
        xlat_t       pending[$];
        int unsigned errors;

        function new();
            win_reg[0] = '0;
            win_reg[1] = '0;
            win_reg[2] = '0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function void set_window(logic [1:0] idx, logic [23:0] v);
            win_reg[idx] = v;
        endfunction

        function aperture_t decode(logic [23:0] r);
            aperture_t d;
            d.sys  = 64'h3000_0000 | (64'(r[19:16]) << 24);
            d.pci  = 64'(r[15:8]) << 24;
            d.size = (64'h100 - (64'hf0 | 64'(r[7:0]))) << 24;
            return d;
        endfunction

        function aperture_t fixed_aperture(logic op);
            aperture_t d;
            if (op == pcowt_pkg::OP_MEM) begin
                d.sys  = 64'h3010_0000;
                d.pci  = 64'h0010_0000;
                d.size = 64'h00f0_0000;
            end else begin
                d.sys  = 64'h3000_0000;
                d.pci  = 64'h0000_0000;
                d.size = 64'h0001_0000;
            end
            return d;
        endfunction

        // k = 0 fixed window, 1/2 programmable windows of that space
        function aperture_t aperture_of(logic op, int k);
            if (k == 0)
                return fixed_aperture(op);
            if (op == pcowt_pkg::OP_IO)
                return decode(win_reg[pcowt_pkg::REG_IO]);
            if (k == 1)
                return decode(win_reg[pcowt_pkg::REG_MEM_A]);
            return decode(win_reg[pcowt_pkg::REG_MEM_B]);
        endfunction

        function bit spans_overlap(aperture_t a, aperture_t b);
            return (a.sys < b.sys + b.size) && (b.sys < a.sys + a.size);
        endfunction

        function bit hits_fixed(aperture_t a);
            return (a.sys < 64'h3100_0000) && (64'h3000_0000 < a.sys + a.size);
        endfunction

        function xlat_t translate(logic op, logic [31:0] addr, logic [31:0] len);
            aperture_t list[3];
            aperture_t ma;
            aperture_t mb;
            aperture_t io;
            bit        ea;
            bit        eb;
            bit        ei;
            int        n;
            logic [63:0] off;
            xlat_t     r;
            ma = decode(win_reg[pcowt_pkg::REG_MEM_A]);
            mb = decode(win_reg[pcowt_pkg::REG_MEM_B]);
            io = decode(win_reg[pcowt_pkg::REG_IO]);
            ea = !hits_fixed(ma);
            eb = !hits_fixed(mb) && !(ea && spans_overlap(mb, ma));
            ei = !hits_fixed(io) && !(ea && spans_overlap(io, ma))
                 && !(eb && spans_overlap(io, mb));
            list[0] = fixed_aperture(op);
            n = 1;
            if (op == pcowt_pkg::OP_MEM) begin
                if (ea) begin
                    list[n] = ma;
                    n++;
                end
                if (eb) begin
                    list[n] = mb;
                    n++;
                end
            end else if (ei) begin
                list[n] = io;
                n++;
            end
            r.hit = 1'b0;
            r.sys_addr = '0;
            r.window_index = pcowt_pkg::IDX_FIXED;
            for (int i = 0; i < n; i++) begin
                if (!r.hit && 64'(addr) >= list[i].pci) begin
                    off = 64'(addr) - list[i].pci;
                    if (off + 64'(len) <= list[i].size) begin
                        r.hit = 1'b1;
                        r.sys_addr = 32'(list[i].sys + off);
                        r.window_index = 2'(i);
                    end
                end
            end
            return r;
        endfunction

        function void note_access(logic op, logic [31:0] addr, logic [31:0] len);
            pending.push_back(translate(op, addr, len));
        endfunction

        task check_result(logic hit, logic [31:0] sys_addr, logic [1:0] widx);
            xlat_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected item hit=%0d sys=%08h idx=%0d",
                                 hit, sys_addr, widx));
                return;
            end
            e = pending.pop_front();
            if (hit !== e.hit)
                report($sformatf("hit %0d, expected %0d", hit, e.hit));
            if (sys_addr !== e.sys_addr)
                report($sformatf("sys_addr %08h, expected %08h", sys_addr, e.sys_addr));
            if (widx !== e.window_index)
                report($sformatf("window_index %0d, expected %0d", widx, e.window_index));
        endtask
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [pcowt_pkg::PADDR_W-1:0] paddr = '0;
    logic [pcowt_pkg::PDATA_W-1:0] pwdata = '0;
    logic [pcowt_pkg::PDATA_W-1:0] prdata;
    logic        pready;

    window_scoreboard sb = new();
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    logic [7:0]  rx_cyc = '0;
    int unsigned rx_mode = 0;

    pci_outbound_window_translate uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result monitor, stall pattern and idle counter
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser[0], m_tdata[31:0], m_tdata[33:32]);
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                        || (psel && penable)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        rx_cyc <= rx_cyc + 8'd1;
        if (rx_cyc == 8'd0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cyc[1:0] == 2'b00);
            default: m_tready <= (rx_cyc[4:3] != 2'b11);
        endcase
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge aclk);
        $display("pci_outbound_window_translate regression: fail");
        $finish;
    end

    task automatic send_access(logic op, logic [31:0] addr, logic [31:0] len);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {len, addr};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.note_access(op, addr, len);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic program_window(logic [1:0] idx, logic [23:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {8'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_window(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[23:0] !== value)
            sb.report($sformatf("register %0d reads %06h, expected %06h",
                                idx, prdata[23:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_all(logic [23:0] a, logic [23:0] b, logic [23:0] io);
        program_window(pcowt_pkg::REG_MEM_A, a);
        program_window(pcowt_pkg::REG_MEM_B, b);
        program_window(pcowt_pkg::REG_IO, io);
    endtask

    function automatic logic [23:0] random_window();
        logic [23:0] v;
        v = 24'($urandom);
        if ($urandom_range(0, 1) == 1)
            v[3:0] = 4'($urandom_range(12, 15));
        return v;
    endfunction

    // aims addresses near window edges, inside a window, near the address top or at random
    task automatic random_access();
        logic        op;
        aperture_t   ap;
        logic [63:0] addr;
        logic [63:0] rem;
        logic [63:0] len;
        op = 1'($urandom_range(0, 1));
        ap = sb.aperture_of(op, $urandom_range(0, 2));
        case ($urandom_range(0, 6))
            0: addr = ap.pci + $urandom_range(0, 3);
            1: addr = ap.pci + ap.size - $urandom_range(0, 4);
            2: addr = ap.pci + ({32'b0, $urandom} % ap.size);
            3: addr = ap.pci - $urandom_range(1, 4);
            4: addr = 64'h0_ffff_ffff - $urandom_range(0, 7);
            default: addr = {32'b0, $urandom};
        endcase
        rem = ap.pci + ap.size - addr;
        case ($urandom_range(0, 6))
            0: len = '0;
            1: len = 64'($urandom_range(1, 16));
            2: len = rem;
            3: len = rem + 1;
            4: len = rem - $urandom_range(0, 3);
            5: len = 64'h0_ffff_ffff - $urandom_range(0, 3);
            default: len = {32'b0, $urandom};
        endcase
        send_access(op, addr[31:0], len[31:0]);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all windows enabled: a at sys 0x32/pci 0x40 (2 units), b at 0x34/0x80, io at 0x36/0xc0
        program_all(24'h02_40_fe, 24'h04_80_ff, 24'h06_c0_f0);
        send_access(pcowt_pkg::OP_MEM, 32'h0010_0000, 32'h0000_0000);
        send_access(pcowt_pkg::OP_MEM, 32'h0010_0000, 32'h00f0_0000);
        send_access(pcowt_pkg::OP_MEM, 32'h0010_0000, 32'h00f0_0001);
        send_access(pcowt_pkg::OP_MEM, 32'h0100_0000, 32'h0000_0000);
        send_access(pcowt_pkg::OP_MEM, 32'h000f_ffff, 32'h0000_0001);
        send_access(pcowt_pkg::OP_MEM, 32'h4000_0000, 32'h0000_0004);
        send_access(pcowt_pkg::OP_MEM, 32'h41ff_fffc, 32'h0000_0004);
        send_access(pcowt_pkg::OP_MEM, 32'h41ff_fffc, 32'h0000_0005);
        send_access(pcowt_pkg::OP_MEM, 32'h8000_0000, 32'h0100_0000);
        send_access(pcowt_pkg::OP_MEM, 32'hffff_ffff, 32'hffff_ffff);
        send_access(pcowt_pkg::OP_MEM, 32'h0000_0000, 32'hffff_ffff);
        send_access(pcowt_pkg::OP_IO,  32'h0000_0000, 32'h0001_0000);
        send_access(pcowt_pkg::OP_IO,  32'h0000_ffff, 32'h0000_0002);
        send_access(pcowt_pkg::OP_IO,  32'hc000_0000, 32'h0000_0000);
        send_access(pcowt_pkg::OP_IO,  32'hcfff_ffff, 32'h0000_0001);
        send_access(pcowt_pkg::OP_MEM, 32'hc000_0000, 32'h0000_0010);
        send_access(pcowt_pkg::OP_IO,  32'h4000_0000, 32'h0000_0010);
        quiesce();

        // a sits on the fixed region, so b moves up to index 1; io overlaps b
        program_all(24'h00_40_fe, 24'h04_80_fe, 24'h05_c0_ff);
        send_access(pcowt_pkg::OP_MEM, 32'h8000_0000, 32'h0000_0008);
        send_access(pcowt_pkg::OP_MEM, 32'h4000_0000, 32'h0000_0008);
        send_access(pcowt_pkg::OP_IO,  32'hc000_0000, 32'h0000_0008);
        quiesce();

        // all ones: b and io both overlap a
        program_all(24'hff_ff_ff, 24'hff_ff_ff, 24'hff_ff_ff);
        send_access(pcowt_pkg::OP_MEM, 32'hff00_0000, 32'h0100_0000);
        send_access(pcowt_pkg::OP_MEM, 32'hffff_ffff, 32'h0000_0001);
        send_access(pcowt_pkg::OP_IO,  32'hff00_0000, 32'h0000_0000);
        quiesce();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: program_all(24'h00_00_00, 24'h00_00_00, 24'h00_00_00);
                1: program_all(24'hff_ff_ff, 24'h00_00_00, 24'hff_ff_ff);
                2: program_all(24'h01_00_f0, 24'h0f_ff_ff, 24'h0e_80_ff);
                default: program_all(random_window(), random_window(), random_window());
            endcase
            repeat (PHASE_ITEMS) random_access();
            quiesce();
        end

        if (sb.errors == 0)
            $display("pci_outbound_window_translate regression: pass");
        else
            $display("pci_outbound_window_translate regression: fail");
        $finish;
    end

endmodule
